// ===== hw/rtl/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and codes of the variable segment allocator
// Segment entry layout, request and status codes, register indexes and the
// control group that the sequencer hands to the segment chain.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int REGION_UNITS     = 65536;

  // One table entry: start offset, length in units, free mark.
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
    logic        free;
  } seg_t;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_PROBE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic [1:0] REG_FIT_POLICY  = 2'd0;
  localparam logic [1:0] REG_REGION_SIZE = 2'd1;
  localparam logic [1:0] REG_SMALL_LIMIT = 2'd2;

  // Control group from the sequencer to the chain of segment cells.
  typedef struct packed {
    logic shift;
    logic load;
    seg_t load_val;
    seg_t tail;
  } ring_ctl_t;

endpackage

// ===== hw/rtl/vsa_cell.sv =====
// ----------------------------------------------------------------------------
// vsa_cell: one segment slot of the chain
// Holds one table entry and takes its neighbor's entry on every shift; a load wins over a shift.
// ----------------------------------------------------------------------------
module vsa_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  vsa_pkg::seg_t load_val,
  input  vsa_pkg::seg_t next_in,
  output vsa_pkg::seg_t q
);
  import vsa_pkg::*;

  seg_t entry;

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_val;
    end else if (shift) begin
      entry <= next_in;
    end
  end

  assign q = entry;

endmodule

// ===== hw/rtl/vsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vsa_ctrl: request sequencer of the segment allocator
// Scans the rotating chain to choose or find a segment or test a probe address,
// then rewrites the chain in a second rotation while it gathers the statistics.
// ----------------------------------------------------------------------------
module vsa_ctrl #(
  parameter int MAX_SEGMENTS = vsa_pkg::MAX_SEGMENTS_DEF,
  localparam int IDX_W = $clog2(MAX_SEGMENTS),
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [16:0]        in_want,
  input  logic [15:0]        in_addr,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  vsa_pkg::seg_t      head,
  input  vsa_pkg::seg_t      next1,
  input  vsa_pkg::seg_t      next2,
  output vsa_pkg::ring_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [15:0]        block_start,
  output logic               probe_hit,
  output logic [CNT_W-1:0]   allocated_blocks,
  output logic [CNT_W-1:0]   free_blocks,
  output logic [16:0]        free_units,
  output logic [16:0]        largest_free,
  output logic [CNT_W-1:0]   small_free_blocks
);
  import vsa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_REWR, S_DONE} state_t;
  typedef enum logic [1:0] {RW_KEEP, RW_REPL, RW_INS} rw_t;

  state_t           state;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] new_total;
  logic [1:0]       fit_pol;
  logic [16:0]      small_lim;
  logic [15:0]      cursor_base;
  logic             cursor_valid;

  mode_t            mode;
  logic [16:0]      want;
  logic [15:0]      addr;
  seg_t             prev;

  // Scan results.
  logic             fa_found, ac_found, pk_found, c_found;
  logic [IDX_W-1:0] fa_idx, ac_idx, pk_idx;
  seg_t             fa_seg, ac_seg, pk_seg;
  logic             f_found, f_just, f_was_free, f_low, f_up;
  logic [IDX_W-1:0] f_idx;
  logic [15:0]      m_base;
  logic [16:0]      m_len;
  logic             hit;

  // Rewrite plan.
  rw_t              rw_kind;
  logic [IDX_W-1:0] rw_at;
  logic [1:0]       rw_drop;
  seg_t             rw_e0, rw_e1;
  logic [2:0]       res_status;
  logic [15:0]      res_start;

  // Statistics gathered during the rewrite.
  logic [CNT_W-1:0] n_alloc, n_free, n_small;
  logic [16:0]      units, big;

  logic             valid_k, fit, cont, probe_in, match, last_k;
  logic             sel_found, use_next;
  logic [IDX_W-1:0] sel_idx;
  seg_t             sel_seg, out_seg;
  logic [16:0]      clamp_size;
  logic             keep_new;

  assign last_k  = (k == IDX_W'(MAX_SEGMENTS - 1));
  assign valid_k = (CNT_W'(k) < total);
  assign fit     = valid_k && head.free && (head.len >= want);
  assign cont    = valid_k && cursor_valid && (cursor_base >= head.base) &&
                   ({1'b0, cursor_base - head.base} < head.len);
  assign probe_in = valid_k && !head.free && (addr >= head.base) &&
                    ({1'b0, addr - head.base} < head.len);
  assign match   = valid_k && (head.base == addr) && !f_found;
  assign keep_new = (CNT_W'(k) < new_total);

  // Candidate selection by policy; next fit with a located cursor prefers the
  // first fit past the cursor segment and wraps to the first fit overall.
  always_comb begin
    use_next = (fit_pol == POL_NEXT) && cursor_valid && c_found;
    if (use_next && ac_found) begin
      sel_found = 1'b1;
      sel_idx   = ac_idx;
      sel_seg   = ac_seg;
    end else if (use_next || fit_pol == POL_FIRST || fit_pol == POL_NEXT) begin
      sel_found = fa_found;
      sel_idx   = fa_idx;
      sel_seg   = fa_seg;
    end else begin
      sel_found = pk_found;
      sel_idx   = pk_idx;
      sel_seg   = pk_seg;
    end
  end

  // Entry written into the tail of the chain during the rewrite rotation.
  always_comb begin
    out_seg = head;
    case (rw_kind)
      RW_REPL: begin
        if (k == rw_at) begin
          out_seg = rw_e0;
        end else if (k > rw_at) begin
          case (rw_drop)
            2'd0:    out_seg = head;
            2'd1:    out_seg = next1;
            default: out_seg = next2;
          endcase
        end
      end
      RW_INS: begin
        if (k == rw_at) begin
          out_seg = rw_e0;
        end else if ({1'b0, k} == {1'b0, rw_at} + 1'b1) begin
          out_seg = rw_e1;
        end else if (k > rw_at) begin
          out_seg = prev;
        end
      end
      default: out_seg = head;
    endcase
  end

  always_comb begin
    if (cfg_data == 17'd0) begin
      clamp_size = 17'd1;
    end else if (cfg_data > 17'(REGION_UNITS)) begin
      clamp_size = 17'(REGION_UNITS);
    end else begin
      clamp_size = cfg_data;
    end
  end

  always_comb begin
    ctl.shift = (state == S_SCAN) || (state == S_REWR);
    ctl.tail  = (state == S_REWR) ? out_seg : head;
    ctl.load  = rst || (cfg_we && cfg_index == REG_REGION_SIZE);
    ctl.load_val.base = 16'd0;
    ctl.load_val.len  = rst ? 17'(REGION_UNITS) : clamp_size;
    ctl.load_val.free = 1'b1;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= CNT_W'(1);
      fit_pol      <= POL_FIRST;
      small_lim    <= 17'd16;
      cursor_valid <= 1'b0;
      cursor_base  <= 16'd0;
      out_valid    <= 1'b0;
      k            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIT_POLICY:  fit_pol <= cfg_data[1:0];
          REG_REGION_SIZE: begin
            total        <= CNT_W'(1);
            cursor_valid <= 1'b0;
          end
          REG_SMALL_LIMIT: small_lim <= cfg_data;
          default: ;
        endcase
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.shift) begin
        prev <= head;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode     <= mode_t'(in_mode);
            want     <= in_want;
            addr     <= in_addr;
            k        <= '0;
            fa_found <= 1'b0;
            ac_found <= 1'b0;
            pk_found <= 1'b0;
            c_found  <= 1'b0;
            f_found  <= 1'b0;
            f_just   <= 1'b0;
            f_up     <= 1'b0;
            hit      <= 1'b0;
            state    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (mode == MODE_ALLOC) begin
            if (fit && !fa_found) begin
              fa_found <= 1'b1;
              fa_idx   <= k;
              fa_seg   <= head;
            end
            if (cont && !c_found) begin
              c_found <= 1'b1;
            end
            if (fit && c_found && !ac_found) begin
              ac_found <= 1'b1;
              ac_idx   <= k;
              ac_seg   <= head;
            end
            if (fit && (!pk_found ||
                        (fit_pol == POL_BEST && head.len < pk_seg.len) ||
                        (fit_pol == POL_WORST && head.len > pk_seg.len))) begin
              pk_found <= 1'b1;
              pk_idx   <= k;
              pk_seg   <= head;
            end
          end
          if (mode == MODE_FREE) begin
            f_just <= match;
            if (match) begin
              f_found    <= 1'b1;
              f_idx      <= k;
              f_was_free <= head.free;
              f_low      <= (k != '0) && prev.free;
              m_base     <= ((k != '0) && prev.free) ? prev.base : head.base;
              m_len      <= head.len + (((k != '0) && prev.free) ? prev.len : 17'd0);
            end
            if (f_just && valid_k && head.free) begin
              f_up  <= 1'b1;
              m_len <= m_len + head.len;
            end
          end
          if (mode == MODE_PROBE && probe_in) begin
            hit <= 1'b1;
          end
          k <= k + 1'b1;
          if (last_k) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          rw_kind    <= RW_KEEP;
          rw_drop    <= 2'd0;
          new_total  <= total;
          res_status <= ST_OK;
          res_start  <= 16'd0;
          unique case (mode)
            MODE_ALLOC: begin
              if (want == 17'd0) begin
                res_status <= ST_BAD_SIZE;
              end else if (!sel_found) begin
                res_status <= ST_NO_FIT;
              end else if (sel_seg.len == want) begin
                rw_kind   <= RW_REPL;
                rw_at     <= sel_idx;
                rw_e0     <= '{base: sel_seg.base, len: want, free: 1'b0};
                res_start <= sel_seg.base;
                if (fit_pol == POL_NEXT) begin
                  cursor_base  <= sel_seg.base;
                  cursor_valid <= 1'b1;
                end
              end else if (total == CNT_W'(MAX_SEGMENTS)) begin
                res_status <= ST_FULL;
              end else begin
                rw_kind   <= RW_INS;
                rw_at     <= sel_idx;
                rw_e0     <= '{base: sel_seg.base, len: want, free: 1'b0};
                rw_e1     <= '{base: sel_seg.base + want[15:0],
                               len: sel_seg.len - want, free: 1'b1};
                new_total <= total + 1'b1;
                res_start <= sel_seg.base;
                if (fit_pol == POL_NEXT) begin
                  cursor_base  <= sel_seg.base;
                  cursor_valid <= 1'b1;
                end
              end
            end
            MODE_FREE: begin
              if (!f_found) begin
                res_status <= ST_NOT_FOUND;
              end else if (!f_was_free) begin
                rw_kind   <= RW_REPL;
                rw_at     <= f_low ? f_idx - 1'b1 : f_idx;
                rw_e0     <= '{base: m_base, len: m_len, free: 1'b1};
                rw_drop   <= {1'b0, f_low} + {1'b0, f_up};
                new_total <= total - CNT_W'({1'b0, f_low} + {1'b0, f_up});
              end
            end
            default: ;
          endcase
          n_alloc <= '0;
          n_free  <= '0;
          n_small <= '0;
          units   <= 17'd0;
          big     <= 17'd0;
          k       <= '0;
          state   <= S_REWR;
        end

        S_REWR: begin
          if (keep_new) begin
            if (out_seg.free) begin
              n_free <= n_free + 1'b1;
              units  <= units + out_seg.len;
              if (out_seg.len > big) begin
                big <= out_seg.len;
              end
              if (out_seg.len < small_lim) begin
                n_small <= n_small + 1'b1;
              end
            end else begin
              n_alloc <= n_alloc + 1'b1;
            end
          end
          k <= k + 1'b1;
          if (last_k) begin
            total <= new_total;
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            block_start       <= res_start;
            probe_hit         <= hit;
            allocated_blocks  <= n_alloc;
            free_blocks       <= n_free;
            free_units        <= units;
            largest_free      <= big;
            small_free_blocks <= n_small;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/variable_segment_allocator_core.sv =====
// ----------------------------------------------------------------------------
// variable_segment_allocator_core: first/best/worst/next-fit segment allocator
// Keeps one region as an address-ordered table of segments held in a chain
// of cells, and serves allocate, free and probe requests on a stream port.
// ----------------------------------------------------------------------------
// Every request, whatever its kind, takes the same path through the segment
// chain: the table lives in MAX_SEGMENTS cells that rotate as one ring, and
// a request needs one full rotation to scan every entry (choosing the
// segment by the fit policy, finding the segment to free or testing the
// probe address) and a second full rotation to write the changed table back
// while the result statistics are summed. A finished result sits in an
// output register, so the next request is taken while that result still
// waits for the consumer. Writing the region size resets the table to one
// free segment. Configuration is to be written by the user only while no
// request is in flight; the block itself does not enforce it.
module variable_segment_allocator_core #(
  parameter int MAX_SEGMENTS = vsa_pkg::MAX_SEGMENTS_DEF,
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1),
  localparam int OUT_W = ((54 + 3 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Request stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,   // request_size[16:0], address[32:17], zero pad
  input  logic [1:0]       s_tuser,   // mode[1:0]
  // Result stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // status, block_start, probe_hit,
                                      // allocated_blocks, free_blocks, free_units,
                                      // largest_free, small_free_blocks, zero pad
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [16:0]      cfg_data
);
  import vsa_pkg::*;

  localparam int TAP2 = (MAX_SEGMENTS > 2) ? 2 : MAX_SEGMENTS - 1;

  ring_ctl_t        ctl;
  seg_t             q [MAX_SEGMENTS];

  logic [2:0]       status;
  logic [15:0]      block_start;
  logic             probe_hit;
  logic [CNT_W-1:0] allocated_blocks, free_blocks, small_free_blocks;
  logic [16:0]      free_units, largest_free;

  // The chain: cell 0 is the head that the sequencer looks at, entries move
  // toward it on every shift and the sequencer feeds the last cell.
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_t nin;
    if (i == MAX_SEGMENTS - 1) begin : g_tail
      assign nin = ctl.tail;
    end else begin : g_link
      assign nin = q[i + 1];
    end
    vsa_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .load     ((i == 0) ? ctl.load : 1'b0),
      .load_val (ctl.load_val),
      .next_in  (nin),
      .q        (q[i])
    );
  end

  vsa_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .in_mode           (s_tuser),
    .in_want           (s_tdata[16:0]),
    .in_addr           (s_tdata[32:17]),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head              (q[0]),
    .next1             (q[1]),
    .next2             (q[TAP2]),
    .ctl               (ctl),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .status            (status),
    .block_start       (block_start),
    .probe_hit         (probe_hit),
    .allocated_blocks  (allocated_blocks),
    .free_blocks       (free_blocks),
    .free_units        (free_units),
    .largest_free      (largest_free),
    .small_free_blocks (small_free_blocks)
  );

  // Result fields packed from the lowest bit up.
  assign m_tdata = OUT_W'({small_free_blocks, largest_free, free_units, free_blocks,
                           allocated_blocks, probe_hit, block_start, status});

endmodule

// ===== dv/segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_checker: scoreboard for the variable segment allocator
// Watches the request, result and configuration ports, keeps its own copy of
// the segment table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module segment_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          errors,
  output int          pending
);
  import vsa_pkg::*;

  localparam int NSEG = MAX_SEGMENTS_DEF;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] start;
    logic        hit;
    logic [6:0]  nalloc;
    logic [6:0]  nfree;
    logic [16:0] units;
    logic [16:0] biggest;
    logic [6:0]  nshort;
  } alloc_result_t;

  logic [1:0]  policy;
  logic [16:0] region_len;
  logic [16:0] short_limit;
  logic [15:0] seg_base [NSEG];
  logic [16:0] seg_len  [NSEG];
  logic        seg_free [NSEG];
  int          seg_count;
  logic [15:0] cursor;
  logic        cursor_ok;

  alloc_result_t result_q[$];

  function automatic void clear_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i] = '0;
      seg_len[i]  = '0;
      seg_free[i] = 1'b0;
    end
    seg_len[0]  = region_len;
    seg_free[0] = 1'b1;
    seg_count   = 1;
    cursor      = '0;
    cursor_ok   = 1'b0;
  endfunction

  function automatic void remove_entry(int r);
    for (int i = r; i + 1 < seg_count; i++) begin
      seg_base[i] = seg_base[i+1];
      seg_len[i]  = seg_len[i+1];
      seg_free[i] = seg_free[i+1];
    end
    seg_count--;
  endfunction

  function automatic bit covers(int i, logic [15:0] a);
    return (a >= seg_base[i]) && ({16'd0, a} - {16'd0, seg_base[i]} < {15'd0, seg_len[i]});
  endfunction

  // Returns the chosen segment index, or seg_count when nothing fits.
  function automatic int pick_segment(logic [16:0] want);
    int pick, c, j;
    logic [1:0] pol;
    pick = seg_count;
    pol  = policy;
    if (pol == POL_NEXT && cursor_ok) begin
      c = seg_count;
      for (int i = 0; i < seg_count; i++)
        if (c == seg_count && covers(i, cursor)) c = i;
      if (c < seg_count) begin
        for (int k = 1; k <= seg_count; k++) begin
          j = (c + k) % seg_count;
          if (seg_free[j] && seg_len[j] >= want) return j;
        end
        return seg_count;
      end
      pol = POL_FIRST;
    end
    for (int i = 0; i < seg_count; i++) begin
      if (!seg_free[i] || seg_len[i] < want) continue;
      if (pol == POL_FIRST || pol == POL_NEXT) return i;
      if (pick == seg_count ||
          (pol == POL_BEST && seg_len[i] < seg_len[pick]) ||
          (pol == POL_WORST && seg_len[i] > seg_len[pick]))
        pick = i;
    end
    return pick;
  endfunction

  function automatic alloc_result_t serve_request(mode_t mode, logic [16:0] want,
                                                  logic [15:0] addr);
    alloc_result_t r;
    int s, f;
    logic [31:0] units;
    r = '{default: '0};
    units = 0;
    case (mode)
      MODE_ALLOC: begin
        if (want == 0) begin
          r.status = ST_BAD_SIZE;
        end else begin
          s = pick_segment(want);
          if (s >= seg_count) begin
            r.status = ST_NO_FIT;
          end else if (seg_len[s] == want) begin
            seg_free[s] = 1'b0;
            r.start = seg_base[s];
          end else if (seg_count >= NSEG) begin
            r.status = ST_FULL;
          end else begin
            for (int i = seg_count; i > s + 1; i--) begin
              seg_base[i] = seg_base[i-1];
              seg_len[i]  = seg_len[i-1];
              seg_free[i] = seg_free[i-1];
            end
            seg_base[s+1] = seg_base[s] + want[15:0];
            seg_len[s+1]  = seg_len[s] - want;
            seg_free[s+1] = 1'b1;
            seg_len[s]    = want;
            seg_free[s]   = 1'b0;
            seg_count++;
            r.start = seg_base[s];
          end
          if (r.status == ST_OK && policy == POL_NEXT) begin
            cursor    = r.start;
            cursor_ok = 1'b1;
          end
        end
      end
      MODE_FREE: begin
        f = seg_count;
        for (int i = 0; i < seg_count; i++)
          if (f == seg_count && seg_base[i] == addr) f = i;
        if (f >= seg_count) begin
          r.status = ST_NOT_FOUND;
        end else if (!seg_free[f]) begin
          seg_free[f] = 1'b1;
          if (f + 1 < seg_count && seg_free[f+1]) begin
            seg_len[f] += seg_len[f+1];
            remove_entry(f + 1);
          end
          if (f > 0 && seg_free[f-1]) begin
            seg_len[f-1] += seg_len[f];
            remove_entry(f);
          end
        end
      end
      MODE_PROBE: begin
        for (int i = 0; i < seg_count; i++)
          if (!seg_free[i] && covers(i, addr)) r.hit = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < seg_count; i++) begin
      if (seg_free[i]) begin
        r.nfree++;
        units += seg_len[i];
        if (seg_len[i] > r.biggest) r.biggest = seg_len[i];
        if (seg_len[i] < short_limit) r.nshort++;
      end else begin
        r.nalloc++;
      end
    end
    r.units = units[16:0];
    return r;
  endfunction

  function automatic void write_register(logic [1:0] idx, logic [16:0] val);
    case (idx)
      REG_FIT_POLICY: policy = val[1:0];
      REG_REGION_SIZE: begin
        region_len = (val == 0) ? 17'd1 : (val > REGION_UNITS) ? 17'(REGION_UNITS) : val;
        clear_table();
      end
      REG_SMALL_LIMIT: short_limit = val;
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors      = 0;
    pending     = 0;
    policy      = POL_FIRST;
    region_len  = 17'(REGION_UNITS);
    short_limit = 17'd16;
    clear_table();
  end

  // Sampled mid-cycle: every input is driven at the rising edge, so the
  // values seen here are the ones the block takes at the next rising edge.
  always @(negedge clk) begin
    alloc_result_t e;
    if (!rst) begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        result_q.push_back(serve_request(mode_t'(s_tuser), s_tdata[16:0], s_tdata[32:17]));
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("status", e.status, m_tdata[2:0]);
          check_field("block_start", e.start, m_tdata[18:3]);
          check_field("probe_hit", e.hit, m_tdata[19]);
          check_field("allocated_blocks", e.nalloc, m_tdata[26:20]);
          check_field("free_blocks", e.nfree, m_tdata[33:27]);
          check_field("free_units", e.units, m_tdata[50:34]);
          check_field("largest_free", e.biggest, m_tdata[67:51]);
          check_field("small_free_blocks", e.nshort, m_tdata[74:68]);
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the variable segment allocator
// Runs directed corner requests, then phases of random allocate, free and
// probe traffic under several register settings, with bursty requests and a
// stalling result consumer. The checker module does all result comparison.
// ----------------------------------------------------------------------------
module testbench;
  import vsa_pkg::*;

  // Cycles without any request or result moving before the run is abandoned.
  localparam int STALL_LIMIT = 20000;
  // Quiet time after the last result.
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int errors;
  int pending;

  // Consumer control: a long hold-off is requested by the stimulus process.
  logic hold_off_req = 1'b0;
  int   hold_left = 0;
  int   stall_style = 0;
  int   style_left = 0;
  int   idle_cycles = 0;

  // Requests in flight (their modes) and starts of live allocations, used to
  // aim free requests at real segments.
  mode_t       mode_q[$];
  logic [15:0] live_starts[$];
  logic [16:0] region_now;

  always #4 clk = ~clk;

  variable_segment_allocator_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  segment_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // Consumer: switches between always ready, coin-toss and mostly stalled
  // stretches, and honors one long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off_req && hold_left == 0) begin
      hold_left    <= 800;
      hold_off_req <= 1'b0;
      m_tready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 2);
        style_left  <= $urandom_range(50, 400);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Bookkeeping of live allocations and the inactivity watchdog.
  always @(negedge clk) begin
    mode_t md;
    if (!rst) begin
      if (s_tvalid && s_tready) mode_q.push_back(mode_t'(s_tuser));
      if (m_tvalid && m_tready && mode_q.size() > 0) begin
        md = mode_q.pop_front();
        if (md == MODE_ALLOC && m_tdata[2:0] == ST_OK) live_starts.push_back(m_tdata[18:3]);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offers one request; called right after a rising edge and returns right
  // after the rising edge at which the request was taken.
  task automatic send_request(mode_t mode, logic [16:0] size, logic [15:0] addr);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, addr, size};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] pol, logic [16:0] region, logic [16:0] limit);
    write_register(REG_FIT_POLICY, pol);
    write_register(REG_REGION_SIZE, region);
    write_register(REG_SMALL_LIMIT, limit);
    region_now = (region == 0) ? 17'd1 : (region > REGION_UNITS) ? 17'(REGION_UNITS) : region;
    live_starts.delete();
  endtask

  // One random request shaped for the current region: mostly sizes small
  // against the region, frees aimed at live segments, some noise.
  task automatic random_request(int size_cap);
    int pick, idx;
    logic [16:0] size;
    logic [15:0] addr;
    pick = $urandom_range(0, 99);
    size = 17'($urandom_range(1, size_cap));
    addr = 16'($urandom_range(0, region_now - 1));
    if (pick < 45) begin
      if ($urandom_range(0, 19) == 0) size = 17'($urandom_range(0, region_now));
      if ($urandom_range(0, 49) == 0) size = 17'(REGION_UNITS);
      if ($urandom_range(0, 49) == 0) size = 17'd0;
      send_request(MODE_ALLOC, size, addr);
    end else if (pick < 82) begin
      if (live_starts.size() > 0 && $urandom_range(0, 9) != 0) begin
        idx  = $urandom_range(0, live_starts.size() - 1);
        addr = live_starts[idx];
        live_starts.delete(idx);
      end else if ($urandom_range(0, 1) == 0) begin
        addr = 16'($urandom);
      end
      send_request(MODE_FREE, 17'($urandom), addr);
    end else if (pick < 96) begin
      if ($urandom_range(0, 4) == 0) addr = 16'($urandom);
      send_request(MODE_PROBE, 17'($urandom), addr);
    end else begin
      send_request(MODE_NOP, 17'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int count, int size_cap);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 200));
      end
      burst--;
      if (n == count / 2 && !hold_off_req && $urandom_range(0, 3) == 0) hold_off_req <= 1'b1;
      random_request(size_cap);
    end
  endtask

  initial begin
    region_now = 17'(REGION_UNITS);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under the reset settings.
    send_request(MODE_ALLOC, 17'd0, 16'd0);            // zero size
    send_request(MODE_ALLOC, 17'd65536, 16'd0);        // exact fit of the whole region
    send_request(MODE_ALLOC, 17'd1, 16'd0);            // nothing free
    send_request(MODE_PROBE, 17'd0, 16'd0);
    send_request(MODE_PROBE, 17'd0, 16'hFFFF);
    send_request(MODE_FREE, 17'd0, 16'd0);
    send_request(MODE_FREE, 17'd0, 16'd0);             // already free
    send_request(MODE_FREE, 17'd0, 16'd5);             // starts no segment
    send_request(MODE_NOP, 17'h1FFFF, 16'hFFFF);
    send_request(MODE_ALLOC, 17'd100, 16'd0);
    send_request(MODE_ALLOC, 17'd7, 16'd0);
    send_request(MODE_PROBE, 17'd0, 16'd99);
    send_request(MODE_PROBE, 17'd0, 16'd100);
    send_request(MODE_PROBE, 17'd0, 16'd107);          // end is exclusive
    send_request(MODE_FREE, 17'd0, 16'd100);
    send_request(MODE_FREE, 17'd0, 16'd0);             // merges with the free segment above
    send_request(MODE_ALLOC, 17'd65537, 16'd0);        // larger than region
    wait_idle();

    // Small region; policy next fit, extreme small limit.
    configure(POL_NEXT, 17'd0, 17'd65536);
    send_request(MODE_PROBE, 17'd0, 16'd1);            // beyond the region
    send_request(MODE_ALLOC, 17'd1, 16'd0);
    send_request(MODE_PROBE, 17'd0, 16'd0);
    send_request(MODE_FREE, 17'd0, 16'd0);
    wait_idle();

    // Fill the table with unit segments, then hit the full-table cases.
    configure(POL_FIRST, 17'd80, 17'd0);
    for (int n = 0; n < 64; n++) send_request(MODE_ALLOC, 17'd1, 16'd0);
    send_request(MODE_FREE, 17'd0, 16'd10);
    send_request(MODE_ALLOC, 17'd1, 16'd0);            // exact fit with a full table
    send_request(MODE_ALLOC, 17'd2, 16'd0);            // split needs an entry
    wait_idle();

    configure(POL_BEST, 17'd1024, 17'd16);
    random_phase(140, 64);
    wait_idle();
    configure(POL_WORST, 17'd4096, 17'd0);
    random_phase(140, 200);
    wait_idle();
    configure(POL_NEXT, 17'd256, 17'd65536);
    random_phase(140, 12);
    wait_idle();
    configure(POL_NEXT, 17'd128, 17'd8);
    hold_off_req <= 1'b1;
    random_phase(140, 3);
    wait_idle();
    configure(POL_FIRST, 17'h1FFFF, 17'd1000);
    random_phase(130, 2000);
    wait_idle();
    configure(POL_BEST, 17'd512, 17'd32);
    random_phase(130, 6);
    wait_idle();
    configure(POL_WORST, 17'd300, 17'd5);
    random_phase(130, 10);
    wait_idle();
    configure(POL_NEXT, 17'd2048, 17'd64);
    random_phase(150, 100);
    wait_idle();

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
